// File: design/dss_pkg.sv
// dss_pkg: shared types, constants and sequencer states for the data set statistics core
// no dependencies; used by dss_div, data_set_statistics_core and dss_checker
package dss_pkg;

  // default for the longest accepted data set
  parameter int unsigned MAX_ELEMENTS_DEF = 16384;

  // fixed-point scaling of the results
  parameter int unsigned MEAN_FRAC = 8;   // mean is sum*2^8/n
  parameter int unsigned VAR_FRAC  = 16;  // variance is scaled by 2^16 before the root

  // shared serial divider: quotient register and step counts
  parameter int unsigned QUO_W      = 32;
  parameter int unsigned STEP_W     = $clog2(QUO_W + 1);
  parameter int unsigned MEAN_STEPS = 16;
  parameter int unsigned VAR_STEPS  = 32;

  // square root: one result bit per step over a QUO_W-bit radicand
  parameter int unsigned ROOT_W = QUO_W / 2;

  // result field widths
  parameter int unsigned MEAN_W  = 16;
  parameter int unsigned SD_W    = 15;
  parameter int unsigned COUNT_W = 15;

  typedef struct packed {
    logic [7:0] element_value;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [MEAN_W-1:0]  mean_q8;
    logic [SD_W-1:0]    stddev_q8;
    logic [COUNT_W-1:0] zero_total;
    logic [COUNT_W-1:0] element_count;
    logic               is_sparse;
    logic               overflow;
  } result_t;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_LAUNCH,
    ST_MEAN,
    ST_MUL_NQ,
    ST_MUL_SS,
    ST_MUL_NN,
    ST_VDIV,
    ST_ROOT
  } state_t;

endpackage

// File: design/dss_mul.sv
// dss_mul: shift-add multiplier, one multiplier bit per cycle
// depends on nothing but its parameters
module dss_mul #(
  parameter int unsigned AW = 23,
  parameter int unsigned BW = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] product
);

  localparam int unsigned CNT_W = $clog2(AW + 1);

  logic [BW-1:0]    hi;
  logic [AW-1:0]    lo;
  logic [BW-1:0]    mcand;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [BW:0]      sum;

  // add the multiplicand when the current multiplier bit is set
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : {(BW + 1){1'b0}});
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(AW);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi    <= '0;
      lo    <= a;
      mcand <= b;
    end else if (running) begin
      hi <= sum[BW:1];
      lo <= {sum[0], lo[AW-1:1]};
    end
  end

endmodule

// File: design/dss_div.sv
// dss_div: restoring divider, one quotient bit per cycle, step count set at start
// depends on dss_pkg
module dss_div #(
  parameter int unsigned DVW = 30
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [dss_pkg::STEP_W-1:0] steps,
  input  logic [DVW-1:0]             rem_init,
  input  logic [dss_pkg::QUO_W-1:0]  low_init,
  input  logic [DVW-1:0]             divisor,
  output logic                       done,
  output logic [dss_pkg::QUO_W-1:0]  quotient
);

  logic [DVW-1:0]             rem;
  logic [dss_pkg::QUO_W-1:0]  low;
  logic [DVW-1:0]             dvs;
  logic [dss_pkg::STEP_W-1:0] cnt;
  logic                       running;
  logic [DVW:0]               trial;
  logic [DVW:0]               diff;
  logic                       fits;

  // bring down the next dividend bit and try a subtract
  assign trial = {rem, low[dss_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= steps;
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == dss_pkg::STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= rem_init;
      low      <= low_init;
      dvs      <= divisor;
      quotient <= '0;
    end else if (running) begin
      rem      <= fits ? diff[DVW-1:0] : trial[DVW-1:0];
      low      <= {low[dss_pkg::QUO_W-2:0], 1'b0};
      quotient <= {quotient[dss_pkg::QUO_W-2:0], fits};
    end
  end

endmodule

// File: design/data_set_statistics_core.sv
// data_set_statistics_core: mean, population standard deviation and zero count of a data set
// depends on dss_pkg, dss_mul and dss_div
//
// usage
//   input channel: data (element_value, last) is taken at a clock edge with start high and
//   busy low. elements of a set are accumulated one per cycle, so a set streams in
//   back to back while busy stays low.
//   the item flagged last closes the set: busy rises the next cycle and the result
//   is worked out bit-serially, then presented on result, with done high for exactly one cycle.
//   busy is low again in that same cycle, so the next set may start right away.
//   after the last item, the mean division, three runs of the shared shift-add multiplier
//   (one multiplier bit per cycle), the variance division and the square root follow in
//   that order; the restoring divider and the root each give one result bit per cycle.
//   CW is the count width (15 for 16384 elements).
//   elements past MAX_ELEMENTS in a set are dropped and flagged in overflow.
//   the receiver cannot stall: done is a one-cycle strobe and must be taken.
//   reset (rst, synchronous) clears the accumulators and returns to accepting items.
module data_set_statistics_core #(
  parameter int unsigned MAX_ELEMENTS = dss_pkg::MAX_ELEMENTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  dss_pkg::item_t   data,
  output logic             done,
  output dss_pkg::result_t result
);

  // count, sum, square sum, product, divider and root widths
  localparam int unsigned CW  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned SW  = CW + 8;
  localparam int unsigned QW  = CW + 16;
  localparam int unsigned NW  = 2 * CW + 16;
  localparam int unsigned DVW = 2 * CW;
  localparam int unsigned PW  = SW + QW;
  localparam int unsigned RCNT_W = $clog2(dss_pkg::ROOT_W + 1);
  localparam int unsigned RREM_W = dss_pkg::ROOT_W + 2;

  dss_pkg::state_t state, state_next;

  // running accumulators
  logic [CW-1:0] count;
  logic [SW-1:0] sum;
  logic [QW-1:0] sq;
  logic [CW-1:0] zeros;
  logic          dropped;

  // accumulator values including the current item
  logic          accept;
  logic          room;
  logic [15:0]   elem_sq;
  logic [CW-1:0] count_upd;
  logic [SW-1:0] sum_upd;
  logic [QW-1:0] sq_upd;
  logic [CW-1:0] zeros_upd;
  logic          dropped_upd;

  // snapshot of a closed set
  logic [CW-1:0] set_n;
  logic [SW-1:0] set_sum;
  logic [QW-1:0] set_sq;
  logic [CW-1:0] set_zeros;
  logic          set_dropped;

  // intermediate results
  logic [dss_pkg::MEAN_W-1:0] mean;
  logic [NW-1:0]              nq;
  logic [NW-1:0]              num;

  // shared multiplier
  logic          mul_start;
  logic          mul_done;
  logic [SW-1:0] mul_a;
  logic [QW-1:0] mul_b;
  logic [PW-1:0] mul_product;

  // shared divider
  logic                       div_start;
  logic                       div_done;
  logic [dss_pkg::STEP_W-1:0] div_steps;
  logic [DVW-1:0]             div_rem_init;
  logic [dss_pkg::QUO_W-1:0]  div_low_init;
  logic [DVW-1:0]             div_divisor;
  logic [dss_pkg::QUO_W-1:0]  div_quotient;

  // square root, two radicand bits per step
  logic                         root_start;
  logic                         root_last;
  logic [dss_pkg::QUO_W-1:0]    rv;
  logic [RREM_W-1:0]            rrem;
  logic [dss_pkg::ROOT_W-1:0]   root;
  logic [RCNT_W-1:0]            rcnt;
  logic [RREM_W+1:0]            rrem2;
  logic [RREM_W+1:0]            rtrial;
  logic                         rfits;
  logic [dss_pkg::ROOT_W-1:0]   root_next;

  assign busy   = (state != dss_pkg::ST_ACC);
  assign accept = start & ~busy;

  // accumulation, one element per cycle while busy is low
  assign room        = count < CW'(MAX_ELEMENTS);
  assign elem_sq     = 16'(data.element_value) * 16'(data.element_value);
  assign count_upd   = room ? count + 1'b1 : count;
  assign sum_upd     = room ? sum + SW'(data.element_value) : sum;
  assign sq_upd      = room ? sq + QW'(elem_sq) : sq;
  assign zeros_upd   = (room && data.element_value == 8'd0) ? zeros + 1'b1 : zeros;
  assign dropped_upd = dropped | ~room;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sum     <= '0;
      sq      <= '0;
      zeros   <= '0;
      dropped <= 1'b0;
    end else if (accept) begin
      if (data.last) begin
        // set closes: start clean for the next one
        count   <= '0;
        sum     <= '0;
        sq      <= '0;
        zeros   <= '0;
        dropped <= 1'b0;
      end else begin
        count   <= count_upd;
        sum     <= sum_upd;
        sq      <= sq_upd;
        zeros   <= zeros_upd;
        dropped <= dropped_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && data.last) begin
      set_n       <= count_upd;
      set_sum     <= sum_upd;
      set_sq      <= sq_upd;
      set_zeros   <= zeros_upd;
      set_dropped <= dropped_upd;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dss_pkg::ST_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dss_pkg::ST_ACC:    if (accept && data.last) state_next = dss_pkg::ST_LAUNCH;
      dss_pkg::ST_LAUNCH: state_next = dss_pkg::ST_MEAN;
      dss_pkg::ST_MEAN:   if (div_done) state_next = dss_pkg::ST_MUL_NQ;
      dss_pkg::ST_MUL_NQ: if (mul_done) state_next = dss_pkg::ST_MUL_SS;
      dss_pkg::ST_MUL_SS: if (mul_done) state_next = dss_pkg::ST_MUL_NN;
      dss_pkg::ST_MUL_NN: if (mul_done) state_next = dss_pkg::ST_VDIV;
      dss_pkg::ST_VDIV:   if (div_done) state_next = dss_pkg::ST_ROOT;
      dss_pkg::ST_ROOT:   if (root_last) state_next = dss_pkg::ST_ACC;
      default:            state_next = dss_pkg::ST_ACC;
    endcase
  end

  // unit launches and operand selection
  always_comb begin
    mul_start    = 1'b0;
    div_start    = 1'b0;
    root_start   = 1'b0;
    mul_a        = SW'(set_n);
    mul_b        = QW'(set_n);
    div_steps    = dss_pkg::STEP_W'(dss_pkg::VAR_STEPS);
    div_rem_init = num[NW-1:dss_pkg::VAR_FRAC];
    div_low_init = dss_pkg::QUO_W'(num[dss_pkg::VAR_FRAC-1:0])
                   << (dss_pkg::QUO_W - dss_pkg::VAR_FRAC);
    div_divisor  = mul_product[DVW-1:0];
    case (state)
      dss_pkg::ST_LAUNCH: begin
        // mean: sum*256/n, the top of the dividend preloads the remainder
        div_start    = 1'b1;
        div_steps    = dss_pkg::STEP_W'(dss_pkg::MEAN_STEPS);
        div_rem_init = DVW'(set_sum >> dss_pkg::MEAN_FRAC);
        div_low_init = dss_pkg::QUO_W'(set_sum[dss_pkg::MEAN_FRAC-1:0])
                       << (dss_pkg::QUO_W - dss_pkg::MEAN_FRAC);
        div_divisor  = DVW'(set_n);
      end
      dss_pkg::ST_MEAN: begin
        // n * square sum
        mul_start = div_done;
        mul_a     = SW'(set_n);
        mul_b     = set_sq;
      end
      dss_pkg::ST_MUL_NQ: begin
        // sum squared
        mul_start = mul_done;
        mul_a     = set_sum;
        mul_b     = QW'(set_sum);
      end
      dss_pkg::ST_MUL_SS: begin
        // n squared
        mul_start = mul_done;
      end
      dss_pkg::ST_MUL_NN: begin
        // scaled variance: num*65536 / n^2
        div_start = mul_done;
      end
      dss_pkg::ST_VDIV: begin
        root_start = div_done;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == dss_pkg::ST_MEAN && div_done) begin
      mean <= div_quotient[dss_pkg::MEAN_W-1:0];
    end
    if (state == dss_pkg::ST_MUL_NQ && mul_done) begin
      nq <= mul_product[NW-1:0];
    end
    if (state == dss_pkg::ST_MUL_SS && mul_done) begin
      // never negative: n*sum(x^2) >= (sum x)^2
      num <= nq - mul_product[NW-1:0];
    end
  end

  dss_mul #(
    .AW (SW),
    .BW (QW)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  dss_div #(
    .DVW (DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .steps    (div_steps),
    .rem_init (div_rem_init),
    .low_init (div_low_init),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // digit-by-digit square root of the scaled variance
  assign rrem2     = {rrem, rv[dss_pkg::QUO_W-1 -: 2]};
  assign rtrial    = {2'b00, root, 2'b01};
  assign rfits     = rrem2 >= rtrial;
  assign root_next = {root[dss_pkg::ROOT_W-2:0], rfits};
  assign root_last = (state == dss_pkg::ST_ROOT) && (rcnt == RCNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt <= '0;
    end else if (root_start) begin
      rcnt <= RCNT_W'(dss_pkg::ROOT_W);
    end else if (state == dss_pkg::ST_ROOT) begin
      rcnt <= rcnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (root_start) begin
      rv   <= div_quotient;
      rrem <= '0;
      root <= '0;
    end else if (state == dss_pkg::ST_ROOT) begin
      rv   <= {rv[dss_pkg::QUO_W-3:0], 2'b00};
      rrem <= rfits ? RREM_W'(rrem2 - rtrial) : rrem2[RREM_W-1:0];
      root <= root_next;
    end
  end

  // result register and one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= root_last;
    end
  end

  always_ff @(posedge clk) begin
    if (root_last) begin
      result.mean_q8       <= mean;
      result.stddev_q8     <= root_next[dss_pkg::SD_W-1:0];
      result.zero_total    <= dss_pkg::COUNT_W'(set_zeros);
      result.element_count <= dss_pkg::COUNT_W'(set_n);
      result.is_sparse     <= {set_zeros, 1'b0} > {1'b0, set_n};
      result.overflow      <= set_dropped;
    end
  end

endmodule

// File: design/dss_checker.sv
// dss_checker: port-level assertions for data_set_statistics_core, bound to the top level
// depends on dss_pkg and data_set_statistics_core
module dss_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input dss_pkg::item_t   data,
  input logic             done,
  input dss_pkg::result_t result
);

  // a closed set makes the block busy
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && data.last |=> busy)
    else $error("last item did not start the computation");

  // a result only ends a computation
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result strobe outside the end of a computation");

  // strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // mean and deviation of 8-bit data stay in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.mean_q8 <= 16'd65280 && result.stddev_q8 <= 15'd32640)
    else $error("mean or deviation out of range");

endmodule

bind data_set_statistics_core dss_checker u_dss_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .data   (data),
  .done   (done),
  .result (result)
);
